// ----- rtl/fbpa_pkg.sv -----
`timescale 1ns / 1ps

package fbpa_pkg;

	// field widths
	localparam int IDX_W = 6;
	localparam int CNT_W = 7;

	// the used map never holds more than this many blocks
	localparam int MAP_DEPTH_MAX = 64;
	localparam int NUM_BLOCKS_DEF = 64;
	localparam logic [CNT_W-1:0] NUM_BLOCKS_RESET = 7'd64;

	// search chunk handled per cycle
	localparam int CHUNK_W = 16;
	localparam int CHUNK_IW = 4;

	// request codes
	localparam logic [1:0] REQ_ALLOC    = 2'd0;
	localparam logic [1:0] REQ_ALLOC_AT = 2'd1;
	localparam logic [1:0] REQ_FREE     = 2'd2;

	typedef enum logic [1:0] {
		STAT_DONE      = 2'd0,
		STAT_NOCHANGE  = 2'd1,
		STAT_EXHAUSTED = 2'd2,
		STAT_RANGE     = 2'd3
	} status_t;

	typedef struct packed {
		logic             busy;
		logic             fwd_found;
		logic [IDX_W-1:0] fwd_idx;
		logic             all_found;
		logic [IDX_W-1:0] all_idx;
	} scan_res_t;

	// position of the lowest set bit, zero when none
	function automatic logic [CHUNK_IW-1:0] lowest_set(input logic [CHUNK_W-1:0] v);
		logic [CHUNK_IW-1:0] r;
		r = '0;
		for (int i = CHUNK_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = CHUNK_IW'(i);
			end
		end
		return r;
	endfunction

	// pool size limited to 1 .. cap
	function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] v,
			input logic [CNT_W-1:0] cap);
		logic [CNT_W-1:0] r;
		r = v;
		if (v == '0) begin
			r = CNT_W'(1);
		end else if (v > cap) begin
			r = cap;
		end
		return r;
	endfunction

endpackage

// ----- rtl/fixed_block_pool_allocator_unit.sv -----
`timescale 1ns / 1ps

// fixed-size block pool allocator: keeps one used bit per block, a first-pass
// cursor and a free-block count. allocate-next (req_type 0) hands out the first
// free block at or after the cursor, then the lowest free block once the cursor
// has run off the end of the pool; allocate-at (1) and free (2) act on
// block_index. each request gives exactly one result with status, index and the
// free count after the request. one request is handled at a time: in_ready is
// high only while the sequencer is idle. allocate-next with a free block runs
// the chunk search, which walks the used map 16 blocks per cycle; allocate-at,
// free and unknown requests skip it. a result waiting on out_ready does not
// stop the next request from being accepted. writing cfg_data sets the pool
// size (0 acts as 1, values above the map size are clamped) and frees every
// block; write it only while no request is in flight.
module fixed_block_pool_allocator_unit import fbpa_pkg::*; #(
	parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	// request channel
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  logic [IDX_W-1:0] block_index,
	// result channel
	output logic             out_valid,
	input  logic             out_ready,
	output logic [1:0]       status,
	output logic [IDX_W-1:0] granted_index,
	output logic [CNT_W-1:0] free_count,
	// pool size write channel
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [CNT_W-1:0] cfg_data
);

	// map holds at most 64 blocks
	localparam int MapDepth = (NUM_BLOCKS < MAP_DEPTH_MAX) ? NUM_BLOCKS : MAP_DEPTH_MAX;
	localparam int MapIw    = $clog2(MapDepth);
	localparam logic [CNT_W-1:0] CapN = CNT_W'(MapDepth);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t           state_q;
	logic [MapDepth-1:0] used_q;
	logic [CNT_W-1:0] n_q;        // effective pool size
	logic [CNT_W-1:0] cursor_q;   // first-pass cursor, never beyond n_q
	logic [CNT_W-1:0] free_q;
	logic [1:0]       req_q;
	logic [IDX_W-1:0] idx_q;

	// output register
	logic             out_valid_q;
	status_t          status_q;
	logic [IDX_W-1:0] granted_q;
	logic [CNT_W-1:0] count_q;

	logic in_fire;
	logic cfg_fire;
	logic fin_fire;
	logic scan_start;

	logic [MapDepth-1:0] fwd_vec;
	logic [MapDepth-1:0] all_vec;
	scan_res_t           scan_res;

	// results of the finishing step
	status_t          fin_status;
	logic [IDX_W-1:0] fin_granted;
	logic             fin_we;
	logic             fin_bit;
	logic [CNT_W-1:0] fin_free;
	logic [CNT_W-1:0] fin_cursor;
	logic             idx_in_pool;
	logic             idx_used;

	assign in_ready  = (state_q == S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_fire  = cfg_valid && cfg_ready;
	// finish once the output register is empty or being emptied
	assign fin_fire  = (state_q == S_FIN) && (!out_valid_q || out_ready);

	// search only when a free block exists
	assign scan_start = in_fire && (req_type == REQ_ALLOC) && (free_q != '0);

	// candidate maps: free blocks in the pool, and those at or past the cursor
	always_comb begin
		for (int i = 0; i < MapDepth; i++) begin
			all_vec[i] = !used_q[i] && (CNT_W'(i) < n_q);
			fwd_vec[i] = all_vec[i] && (CNT_W'(i) >= cursor_q);
		end
	end

	fbpa_scan #(
		.MAP_DEPTH (MapDepth)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (scan_start),
		.fwd_vec (fwd_vec),
		.all_vec (all_vec),
		.res     (scan_res)
	);

	assign idx_in_pool = ({1'b0, idx_q} < n_q);
	assign idx_used    = used_q[idx_q[MapIw-1:0]];

	always_comb begin
		fin_status  = STAT_NOCHANGE;
		fin_granted = '0;
		fin_we      = 1'b0;
		fin_bit     = 1'b0;
		fin_free    = free_q;
		fin_cursor  = cursor_q;
		case (req_q)
			REQ_ALLOC: begin
				fin_status = STAT_EXHAUSTED;
				if (free_q != '0) begin
					if (scan_res.fwd_found) begin
						// first pass: block at the cursor, skipping taken ones
						fin_status  = STAT_DONE;
						fin_granted = scan_res.fwd_idx;
						fin_cursor  = {1'b0, scan_res.fwd_idx} + CNT_W'(1);
					end else begin
						// cursor has run off the pool: lowest free block
						fin_cursor = n_q;
						if (scan_res.all_found) begin
							fin_status  = STAT_DONE;
							fin_granted = scan_res.all_idx;
						end
					end
					if (fin_status == STAT_DONE) begin
						fin_we   = 1'b1;
						fin_bit  = 1'b1;
						fin_free = free_q - CNT_W'(1);
					end
				end
			end
			REQ_ALLOC_AT: begin
				if (!idx_in_pool) begin
					fin_status = STAT_RANGE;
				end else begin
					fin_granted = idx_q;
					if (!idx_used) begin
						fin_status = STAT_DONE;
						fin_we     = 1'b1;
						fin_bit    = 1'b1;
						if (free_q != '0) begin
							fin_free = free_q - CNT_W'(1);
						end
					end
				end
			end
			REQ_FREE: begin
				if (!idx_in_pool) begin
					fin_status = STAT_RANGE;
				end else begin
					fin_granted = idx_q;
					if (idx_used) begin
						fin_status = STAT_DONE;
						fin_we     = 1'b1;
						fin_bit    = 1'b0;
						if (free_q < n_q) begin
							fin_free = free_q + CNT_W'(1);
						end
					end
				end
			end
			default: begin
				// unknown request: no change, index reads zero
				fin_status = STAT_NOCHANGE;
			end
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (scan_start) begin
						state_q <= S_SCAN;
					end else if (in_fire) begin
						state_q <= S_FIN;
					end
				end
				S_SCAN: begin
					if (!scan_res.busy) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (fin_fire) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q <= REQ_ALLOC;
			idx_q <= '0;
		end else if (in_fire) begin
			req_q <= req_type;
			idx_q <= block_index;
		end
	end

	// pool state: used map, cursor, free count, pool size
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q   <= '0;
			n_q      <= clamp_count(NUM_BLOCKS_RESET, CapN);
			cursor_q <= '0;
			free_q   <= clamp_count(NUM_BLOCKS_RESET, CapN);
		end else if (cfg_fire) begin
			// new pool size frees everything
			used_q   <= '0;
			n_q      <= clamp_count(cfg_data, CapN);
			cursor_q <= '0;
			free_q   <= clamp_count(cfg_data, CapN);
		end else if (fin_fire) begin
			if (fin_we) begin
				used_q[fin_granted[MapIw-1:0]] <= fin_bit;
			end
			cursor_q <= fin_cursor;
			free_q   <= fin_free;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status_q    <= STAT_DONE;
			granted_q   <= '0;
			count_q     <= '0;
		end else begin
			if (fin_fire) begin
				out_valid_q <= 1'b1;
				status_q    <= fin_status;
				granted_q   <= fin_granted;
				count_q     <= fin_free;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign granted_index = granted_q;
	assign free_count    = count_q;

`ifndef SYNTH
	// free count always matches the number of unused blocks in the pool
	assert property (@(posedge clk) disable iff (!arst_n)
		(CNT_W'($countones(used_q)) + free_q) == n_q)
		else $error("free count out of step with used map");

	// cursor never passes the end of the pool
	assert property (@(posedge clk) disable iff (!arst_n)
		cursor_q <= n_q)
		else $error("cursor beyond pool");

	// one request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("request taken while busy");

	// search runs only inside the scan phase
	assert property (@(posedge clk) disable iff (!arst_n)
		scan_res.busy |-> (state_q == S_SCAN))
		else $error("search active outside scan phase");

	// a completed allocate-next always leaves its block marked used
	assert property (@(posedge clk) disable iff (!arst_n)
		(fin_fire && (req_q == REQ_ALLOC) && (fin_status == STAT_DONE))
		|=> used_q[$past(fin_granted[MapIw-1:0])])
		else $error("granted block not marked used");
`endif

endmodule

// ----- rtl/fbpa_scan.sv -----
`timescale 1ns / 1ps

module fbpa_scan import fbpa_pkg::*; #(
	parameter int MAP_DEPTH = MAP_DEPTH_MAX
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [MAP_DEPTH-1:0] fwd_vec,
	input  logic [MAP_DEPTH-1:0] all_vec,
	output scan_res_t            res
);

	localparam int NumChunks = (MAP_DEPTH + CHUNK_W - 1) / CHUNK_W;
	localparam int PadW      = NumChunks * CHUNK_W;
	localparam int LeftW     = $clog2(NumChunks + 1);

	logic [PadW-1:0]  fwd_q;
	logic [PadW-1:0]  all_q;
	logic [CNT_W-1:0] base_q;
	logic [LeftW-1:0] left_q;
	logic             fwd_found_q;
	logic [IDX_W-1:0] fwd_idx_q;
	logic             all_found_q;
	logic [IDX_W-1:0] all_idx_q;

	logic [CHUNK_W-1:0] fwd_chunk;
	logic [CHUNK_W-1:0] all_chunk;
	logic [IDX_W-1:0]   fwd_pos;
	logic [IDX_W-1:0]   all_pos;

	// chunk search on both maps: lowest set bit of the current chunk
	assign fwd_chunk = fwd_q[CHUNK_W-1:0];
	assign all_chunk = all_q[CHUNK_W-1:0];
	assign fwd_pos   = IDX_W'(base_q + CNT_W'(lowest_set(fwd_chunk)));
	assign all_pos   = IDX_W'(base_q + CNT_W'(lowest_set(all_chunk)));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q       <= '0;
			all_q       <= '0;
			base_q      <= '0;
			left_q      <= '0;
			fwd_found_q <= 1'b0;
			fwd_idx_q   <= '0;
			all_found_q <= 1'b0;
			all_idx_q   <= '0;
		end else if (start) begin
			fwd_q       <= PadW'(fwd_vec);
			all_q       <= PadW'(all_vec);
			base_q      <= '0;
			left_q      <= LeftW'(NumChunks);
			fwd_found_q <= 1'b0;
			all_found_q <= 1'b0;
		end else if (left_q != '0) begin
			fwd_q  <= fwd_q >> CHUNK_W;
			all_q  <= all_q >> CHUNK_W;
			base_q <= base_q + CNT_W'(CHUNK_W);
			left_q <= left_q - LeftW'(1);
			if (!fwd_found_q && (|fwd_chunk)) begin
				fwd_found_q <= 1'b1;
				fwd_idx_q   <= fwd_pos;
			end
			if (!all_found_q && (|all_chunk)) begin
				all_found_q <= 1'b1;
				all_idx_q   <= all_pos;
			end
		end
	end

	assign res.busy      = (left_q != '0);
	assign res.fwd_found = fwd_found_q;
	assign res.fwd_idx   = fwd_idx_q;
	assign res.all_found = all_found_q;
	assign res.all_idx   = all_idx_q;

endmodule

// ----- tb/tb_fixed_block_pool_allocator_unit.sv -----
`timescale 1ns / 1ps

module tb_fixed_block_pool_allocator_unit;
	import fbpa_pkg::*;

	// request kind with no meaning to the block, answered with no change
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	typedef struct {
		logic [1:0]       kind;
		logic [IDX_W-1:0] idx;
	} pool_req_t;

	typedef struct {
		status_t          status;
		logic [IDX_W-1:0] index;
		logic [CNT_W-1:0] free;
	} grant_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	// request channel, driven only by the driver below
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       req_type = REQ_ALLOC;
	logic [IDX_W-1:0] block_index = '0;

	// result channel
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [1:0]       status;
	logic [IDX_W-1:0] granted_index;
	logic [CNT_W-1:0] free_count;

	// pool size write channel, driven only by the stimulus block
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	fixed_block_pool_allocator_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.block_index  (block_index),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_index(granted_index),
		.free_count   (free_count),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// requests waiting to be driven, and results the predictor has worked out
	pool_req_t req_backlog[$];
	grant_t    expected_grants[$];

	// idle rates in percent for the sender and the receiver
	int unsigned in_idle_pct = 0;
	int unsigned out_idle_pct = 0;

	// handshakes seen at the last rising edge, read by the falling-edge logic
	logic req_taken = 1'b0;
	logic cfg_taken = 1'b0;

	int failures = 0;

	// predicted pool state
	logic [CNT_W-1:0] pool_limit = NUM_BLOCKS_RESET;
	bit               block_used[MAP_DEPTH_MAX];
	int               scan_cursor = 0;
	int               blocks_free = 64;

	// effective pool size: zero acts as one, the top is the map size
	function automatic int clamp_pool(input logic [CNT_W-1:0] v);
		int cap;
		cap = (NUM_BLOCKS_DEF < MAP_DEPTH_MAX) ? NUM_BLOCKS_DEF : MAP_DEPTH_MAX;
		if (v == '0) begin
			return 1;
		end
		return (int'(v) > cap) ? cap : int'(v);
	endfunction

	// a size write frees every block and rewinds the cursor
	function automatic void pool_load(input logic [CNT_W-1:0] v);
		pool_limit = v;
		foreach (block_used[i]) begin
			block_used[i] = 1'b0;
		end
		scan_cursor = 0;
		blocks_free = clamp_pool(v);
	endfunction

	// next state of the pool and the result for one request
	function automatic grant_t grant_predict(input logic [1:0] kind,
			input logic [IDX_W-1:0] idx);
		grant_t g;
		int n;
		bit found;
		n = clamp_pool(pool_limit);
		g.status = STAT_NOCHANGE;
		g.index = '0;
		found = 1'b0;
		case (kind)
			REQ_ALLOC: begin
				if (blocks_free != 0) begin
					// first pass: skip blocks taken by allocate-at
					while (scan_cursor < n && block_used[scan_cursor]) begin
						scan_cursor++;
					end
					if (scan_cursor < n) begin
						g.index = IDX_W'(scan_cursor);
						scan_cursor++;
						found = 1'b1;
					end else begin
						// cursor ran off the end: lowest free block
						for (int i = 0; i < n; i++) begin
							if (!found && !block_used[i]) begin
								g.index = IDX_W'(i);
								found = 1'b1;
							end
						end
					end
				end
				if (found) begin
					block_used[g.index] = 1'b1;
					blocks_free--;
					g.status = STAT_DONE;
				end else begin
					g.index = '0;
					g.status = STAT_EXHAUSTED;
				end
			end
			REQ_ALLOC_AT, REQ_FREE: begin
				if (int'(idx) >= n) begin
					g.status = STAT_RANGE;
				end else begin
					g.index = idx;
					if (kind == REQ_ALLOC_AT && !block_used[idx]) begin
						block_used[idx] = 1'b1;
						if (blocks_free != 0) begin
							blocks_free--;
						end
						g.status = STAT_DONE;
					end else if (kind == REQ_FREE && block_used[idx]) begin
						block_used[idx] = 1'b0;
						if (blocks_free < n) begin
							blocks_free++;
						end
						g.status = STAT_DONE;
					end
				end
			end
			default: ;
		endcase
		g.free = CNT_W'(blocks_free);
		return g;
	endfunction

	// driver: a new request goes out once the last one was taken, inputs move on
	// the falling edge so the block sees them settled at the next rising edge
	pool_req_t next_req;
	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= out_idle_pct);
			if (!in_valid || req_taken) begin
				if (req_backlog.size() != 0 && $urandom_range(99) >= in_idle_pct) begin
					next_req = req_backlog.pop_front();
					in_valid <= 1'b1;
					req_type <= next_req.kind;
					block_index <= next_req.idx;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor: results are checked against the oldest prediction, accepted
	// requests and size writes update the predicted pool
	grant_t got;
	always @(posedge clk) begin
		req_taken <= in_valid && in_ready;
		cfg_taken <= cfg_valid && cfg_ready;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_grants.size() == 0) begin
					$error("result with no request outstanding: status %0d index %0d free %0d",
						status, granted_index, free_count);
					failures++;
				end else begin
					got = expected_grants.pop_front();
					if (status !== got.status) begin
						$error("status: expected %0d, got %0d", got.status, status);
						failures++;
					end
					if (granted_index !== got.index) begin
						$error("granted_index: expected %0d, got %0d", got.index,
							granted_index);
						failures++;
					end
					if (free_count !== got.free) begin
						$error("free_count: expected %0d, got %0d", got.free, free_count);
						failures++;
					end
				end
			end
			if (in_valid && in_ready) begin
				expected_grants.push_back(grant_predict(req_type, block_index));
			end
			if (cfg_valid && cfg_ready) begin
				pool_load(cfg_data);
			end
		end
	end

	task automatic queue_req(input logic [1:0] kind, input int idx);
		pool_req_t r;
		r.kind = kind;
		r.idx = IDX_W'(idx);
		req_backlog.push_back(r);
	endtask

	// wait until every request has been driven and answered
	task automatic drain();
		@(posedge clk);
		while (req_backlog.size() != 0 || in_valid || expected_grants.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// size write, only with the block idle
	task automatic write_pool_size(input logic [CNT_W-1:0] v);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
		end while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	// one pool size, then a burst of requests mostly aimed inside the pool
	task automatic run_segment(input logic [CNT_W-1:0] size, input int count);
		int n;
		int alloc_pct;
		int roll;
		int at_pct;
		write_pool_size(size);
		n = clamp_pool(size);
		alloc_pct = $urandom_range(25, 75);
		at_pct = alloc_pct + (95 - alloc_pct) / 2;
		for (int i = 0; i < count; i++) begin
			roll = $urandom_range(99);
			if (roll < alloc_pct) begin
				queue_req(REQ_ALLOC, $urandom_range(63));
			end else if (roll < 95) begin
				queue_req((roll < at_pct) ? REQ_ALLOC_AT : REQ_FREE,
					($urandom_range(9) < 8) ? $urandom_range(n - 1) : $urandom_range(63));
			end else begin
				queue_req(REQ_UNKNOWN, $urandom_range(63));
			end
		end
	endtask

	initial begin
		logic [CNT_W-1:0] seg_size;
		pool_load(NUM_BLOCKS_RESET);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed, full 64-block pool out of reset
		in_idle_pct = 16;
		out_idle_pct = 78;
		queue_req(REQ_ALLOC, 63);       // cursor hands out block 0
		queue_req(REQ_ALLOC_AT, 63);    // top block
		queue_req(REQ_ALLOC_AT, 63);    // already used
		queue_req(REQ_FREE, 63);
		queue_req(REQ_FREE, 63);        // already free
		queue_req(REQ_ALLOC_AT, 1);     // at the cursor
		queue_req(REQ_ALLOC, 0);        // cursor skips block 1
		queue_req(REQ_UNKNOWN, 63);
		queue_req(REQ_FREE, 0);

		// directed, tiny pool: exhaustion, range and wrap to lowest free
		write_pool_size(7'd4);
		queue_req(REQ_ALLOC, 0);
		queue_req(REQ_ALLOC, 0);
		queue_req(REQ_ALLOC, 0);
		queue_req(REQ_ALLOC, 0);
		queue_req(REQ_ALLOC, 0);        // nothing left
		queue_req(REQ_ALLOC_AT, 4);     // past the pool
		queue_req(REQ_FREE, 63);        // past the pool
		queue_req(REQ_FREE, 2);
		queue_req(REQ_FREE, 0);
		queue_req(REQ_ALLOC, 0);        // cursor past end, lowest free is 0
		queue_req(REQ_ALLOC_AT, 2);
		queue_req(REQ_ALLOC, 0);        // exhausted again

		// random phases with different idle patterns
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					in_idle_pct = 16;
					out_idle_pct = 78;
				end
				1: begin
					in_idle_pct = 78;
					out_idle_pct = 16;
				end
				default: begin
					in_idle_pct = 0;
					out_idle_pct = 0;
				end
			endcase
			for (int s = 0; s < 8; s++) begin
				if (s == 0) begin
					seg_size = (p == 0) ? 7'd0 : (p == 1) ? 7'd127 : 7'd64;
				end else if (s == 1) begin
					seg_size = (p == 1) ? 7'd64 : 7'd1;
				end else if ($urandom_range(99) < 15) begin
					seg_size = CNT_W'($urandom_range(17, 127));
				end else begin
					seg_size = CNT_W'($urandom_range(1, 16));
				end
				run_segment(seg_size, (clamp_pool(seg_size) >= 32) ? 100 : 55);
			end
		end

		drain();
		repeat (16) @(posedge clk);
		if (failures == 0 && expected_grants.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule

// ----- files.f -----
rtl/fbpa_pkg.sv
rtl/fbpa_scan.sv
rtl/fixed_block_pool_allocator_unit.sv
tb/tb_fixed_block_pool_allocator_unit.sv
